// File: rtl/ifcs_pkg.sv
// ----------------------------------------------------------------------------
// ifcs_pkg: shared types and constants of the IPv4 frame classifier
// Field widths, request and result codes, and the query that travels along
// the address table cells.
// ----------------------------------------------------------------------------
`default_nettype none
package ifcs_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int USED_W      = $clog2(TABLE_DEPTH + 1);
    localparam int BUSY_W      = $clog2(TABLE_DEPTH + 3);
    localparam int HDR_LEN     = 22;
    localparam int HDR_FIRST   = 12;
    localparam logic [10:0] POS_MAX   = 11'd2047;
    localparam logic [10:0] POS_SHORT = 11'd33;
    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;

    typedef enum logic [1:0] {
        FUNC_BYTE  = 2'd0,
        FUNC_COUNT = 2'd1,
        FUNC_SLOT  = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        KIND_IPV4  = 3'd0,
        KIND_OTHER = 3'd1,
        KIND_COUNT = 3'd2,
        KIND_ENTRY = 3'd3,
        KIND_EMPTY = 3'd4
    } kind_t;

    localparam logic [3:0] IDX_TOTAL   = 4'd13;
    localparam logic [3:0] IDX_DROPPED = 4'd14;

    // Address lookup travelling along the table cells.
    typedef struct packed {
        logic        valid;
        logic        done;
        logic        is_src;
        logic [31:0] addr;
    } query_t;

    function automatic logic [3:0] classify(input logic [7:0] proto);
        logic [3:0] cls;
        case (proto)
            8'd1:    cls = 4'd1;
            8'd2:    cls = 4'd2;
            8'd4:    cls = 4'd3;
            8'd6:    cls = 4'd4;
            8'd17:   cls = 4'd5;
            8'd41:   cls = 4'd6;
            8'd89:   cls = 4'd7;
            8'd132:  cls = 4'd8;
            default: cls = 4'd0;
        endcase
        return cls;
    endfunction

endpackage
`default_nettype wire

// File: rtl/ipv4_frame_classifier_stats.sv
// ----------------------------------------------------------------------------
// ipv4_frame_classifier_stats: IPv4 header classifier with traffic counters
// Captures EtherType and IPv4 header, summarises each frame, keeps protocol,
// size and total counters and a per-address table of sent/received counts.
// ----------------------------------------------------------------------------
//  channel   direction  tuser            tdata / tlast
//  s_axis    in         func             data_byte, read_index; tlast last_byte
//  m_axis    out        kind             summary fields, word_a..word_c
//
//  The end of an IPv4 frame sends two lookups down the row of table cells,
//  one cell per cycle, and no transfer is taken until the busy count has run
//  down. Reset is synchronous and clears the frame counters, the table fill
//  count and control state; the cell contents are not cleared. A stalled
//  result holds the input off until it has been taken.
// ----------------------------------------------------------------------------
`default_nettype none
module ipv4_frame_classifier_stats (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [15:0]  s_axis_tdata,  // data_byte[7:0], read_index[13:8]
    input  wire logic [1:0]   s_axis_tuser,  // func
    input  wire logic         s_axis_tlast,  // last_byte
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // protocol_class[3:0], size_bucket[6:4], payload_length[23:7],
    // precedence[26:24], tos_flags[30:27], fragment_kind[32:31],
    // fragment_first[48:33], fragment_last[66:49], word_a[98:67],
    // word_b[130:99], word_c[162:131]
    output logic [167:0]      m_axis_tdata,
    output logic [2:0]        m_axis_tuser   // kind
);

    localparam int D = ifcs_pkg::TABLE_DEPTH;

    logic [7:0]  data_byte;
    logic [5:0]  read_index;
    ifcs_pkg::func_t func;
    logic        accept;

    assign data_byte  = s_axis_tdata[7:0];
    assign read_index = s_axis_tdata[13:8];
    assign func       = ifcs_pkg::func_t'(s_axis_tuser);

    logic [7:0]  hdr_reg [ifcs_pkg::HDR_LEN];
    logic [7:0]  hdr     [ifcs_pkg::HDR_LEN];
    logic [10:0] pos_reg;
    logic [31:0] proto_cnt_reg [8];
    logic [31:0] bucket_cnt_reg [5];
    logic [31:0] total_reg, dropped_reg;
    logic [ifcs_pkg::USED_W-1:0] used_reg;
    logic [ifcs_pkg::BUSY_W-1:0] busy_reg;
    ifcs_pkg::query_t feed_reg, pend_reg;

    logic        out_valid_reg;
    logic [2:0]  kind_reg;
    logic [162:0] out_data_reg;

    assign s_axis_tready = (busy_reg == '0) && (!out_valid_reg || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Header with the byte of this transfer already in place.
    always_comb begin
        for (int i = 0; i < ifcs_pkg::HDR_LEN; i++) begin
            hdr[i] = (pos_reg == 11'(i + ifcs_pkg::HDR_FIRST)) ? data_byte : hdr_reg[i];
        end
    end

    // Frame summary
    logic [15:0] ethertype, tot_len, frag;
    logic [16:0] payload;
    logic [2:0]  bucket;
    logic [3:0]  cls;
    logic [1:0]  fkind;
    logic [15:0] ffirst;
    logic [17:0] flast;
    logic        is_ipv4;
    logic [31:0] src_addr, dst_addr;

    always_comb begin
        ethertype = {hdr[0], hdr[1]};
        tot_len   = {hdr[4], hdr[5]};
        frag      = {hdr[8], hdr[9]};
        payload   = {1'b0, tot_len} - {11'd0, hdr[2][3:0], 2'b00};
        if ($signed(payload) < $signed(17'd160)) begin
            bucket = 3'd0;
        end else if ($signed(payload) < $signed(17'd640)) begin
            bucket = 3'd1;
        end else if ($signed(payload) < $signed(17'd1280)) begin
            bucket = 3'd2;
        end else if ($signed(payload) < $signed(17'd5120)) begin
            bucket = 3'd3;
        end else begin
            bucket = 3'd4;
        end
        cls      = ifcs_pkg::classify(hdr[11]);
        fkind    = {frag[13], frag[12:0] != 13'd0};
        ffirst   = {frag[12:0], 3'b000};
        flast    = {2'b00, ffirst} + {2'b00, tot_len} - 18'd1;
        is_ipv4  = (pos_reg >= ifcs_pkg::POS_SHORT) && (ethertype == ifcs_pkg::ETYPE_IPV4);
        src_addr = {hdr[14], hdr[15], hdr[16], hdr[17]};
        dst_addr = {hdr[18], hdr[19], hdr[20], hdr[21]};
    end

    // Address table: a row of cells, lookups hop one cell per cycle.
    ifcs_pkg::query_t q [D+1];
    logic [D-1:0]  fills;
    logic [31:0]   cell_addr [D];
    logic [31:0]   cell_sent [D];
    logic [31:0]   cell_recv [D];

    assign q[0] = feed_reg;

    for (genvar k = 0; k < D; k++) begin : g_cell
        ifcs_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .slot_valid (used_reg > ifcs_pkg::USED_W'(k)),
            .q_in       (q[k]),
            .q_out      (q[k+1]),
            .fill       (fills[k]),
            .entry_addr (cell_addr[k]),
            .entry_sent (cell_sent[k]),
            .entry_recv (cell_recv[k])
        );
    end

    // Read-back selection
    logic [31:0] cnt_val, slot_a, slot_b, slot_c;
    logic        slot_ok;

    always_comb begin
        if (read_index < 6'd8) begin
            cnt_val = proto_cnt_reg[read_index[2:0]];
        end else if (read_index < 6'd13) begin
            cnt_val = bucket_cnt_reg[3'(read_index - 6'd8)];
        end else if (read_index == {2'b00, ifcs_pkg::IDX_TOTAL}) begin
            cnt_val = total_reg;
        end else if (read_index == {2'b00, ifcs_pkg::IDX_DROPPED}) begin
            cnt_val = dropped_reg;
        end else begin
            cnt_val = '0;
        end
        slot_a = '0;
        slot_b = '0;
        slot_c = '0;
        for (int k = 0; k < D; k++) begin
            if (read_index == 6'(k)) begin
                slot_a = cell_addr[k];
                slot_b = cell_sent[k];
                slot_c = cell_recv[k];
            end
        end
        slot_ok = {{(7 - ifcs_pkg::USED_W){1'b0}}, used_reg} > {1'b0, read_index};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ifcs_pkg::HDR_LEN; i++) begin
                hdr_reg[i] <= '0;
            end
            for (int i = 0; i < 8; i++) begin
                proto_cnt_reg[i] <= '0;
            end
            for (int i = 0; i < 5; i++) begin
                bucket_cnt_reg[i] <= '0;
            end
            pos_reg       <= '0;
            total_reg     <= '0;
            dropped_reg   <= '0;
            used_reg      <= '0;
            busy_reg      <= '0;
            feed_reg      <= '0;
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (|fills) begin
                used_reg <= used_reg + ifcs_pkg::USED_W'(1);
            end
            if (q[D].valid && !q[D].done) begin
                dropped_reg <= dropped_reg + 32'd1;
            end
            if (busy_reg != '0) begin
                busy_reg <= busy_reg - ifcs_pkg::BUSY_W'(1);
            end
            // Destination lookup enters the cells in the cycle after the source lookup.
            feed_reg <= pend_reg;
            pend_reg <= '0;

            if (accept) begin
                case (func)
                    ifcs_pkg::FUNC_BYTE: begin
                        for (int i = 0; i < ifcs_pkg::HDR_LEN; i++) begin
                            hdr_reg[i] <= hdr[i];
                        end
                        if (!s_axis_tlast) begin
                            if (pos_reg != ifcs_pkg::POS_MAX) begin
                                pos_reg <= pos_reg + 11'd1;
                            end
                        end else begin
                            pos_reg       <= '0;
                            total_reg     <= total_reg + 32'd1;
                            out_valid_reg <= 1'b1;
                            if (is_ipv4) begin
                                bucket_cnt_reg[bucket] <= bucket_cnt_reg[bucket] + 32'd1;
                                if (cls != 4'd0) begin
                                    proto_cnt_reg[3'(cls - 4'd1)] <=
                                        proto_cnt_reg[3'(cls - 4'd1)] + 32'd1;
                                end
                                feed_reg <= '{valid: 1'b1, done: 1'b0, is_src: 1'b1,
                                              addr: src_addr};
                                pend_reg <= '{valid: 1'b1, done: 1'b0, is_src: 1'b0,
                                              addr: dst_addr};
                                busy_reg <= ifcs_pkg::BUSY_W'(D + 2);
                            end
                        end
                    end
                    ifcs_pkg::FUNC_COUNT, ifcs_pkg::FUNC_SLOT: begin
                        out_valid_reg <= 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            out_data_reg <= '0;
            case (func)
                ifcs_pkg::FUNC_BYTE: begin
                    if (is_ipv4) begin
                        kind_reg <= ifcs_pkg::KIND_IPV4;
                        out_data_reg[66:0] <= {flast, ffirst, fkind, hdr[3][4:1],
                                               hdr[3][7:5], payload, bucket, cls};
                    end else begin
                        kind_reg <= ifcs_pkg::KIND_OTHER;
                    end
                end
                ifcs_pkg::FUNC_COUNT: begin
                    kind_reg <= ifcs_pkg::KIND_COUNT;
                    out_data_reg[98:67] <= cnt_val;
                end
                ifcs_pkg::FUNC_SLOT: begin
                    if (slot_ok) begin
                        kind_reg <= ifcs_pkg::KIND_ENTRY;
                        out_data_reg[162:67] <= {slot_c, slot_b, slot_a};
                    end else begin
                        kind_reg <= ifcs_pkg::KIND_EMPTY;
                    end
                end
                default: begin
                    kind_reg <= ifcs_pkg::KIND_OTHER;
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = kind_reg;
    assign m_axis_tdata  = {5'd0, out_data_reg};

endmodule
`default_nettype wire

// File: rtl/ifcs_cell.sv
// ----------------------------------------------------------------------------
// ifcs_cell: one slot of the address table
// Holds an address with its sent and received counts, serves the lookup that
// passes by and hands it on to the next cell through a register.
// ----------------------------------------------------------------------------
`default_nettype none
module ifcs_cell (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            slot_valid,
    input  ifcs_pkg::query_t     q_in,
    output ifcs_pkg::query_t     q_out,
    output logic                 fill,
    output logic [31:0]          entry_addr,
    output logic [31:0]          entry_sent,
    output logic [31:0]          entry_recv
);

    logic [31:0] addr_reg, sent_reg, recv_reg;
    ifcs_pkg::query_t q_reg, q_next;
    logic hit, active;

    assign active = q_in.valid && !q_in.done;
    assign hit    = active && slot_valid && (addr_reg == q_in.addr);
    // Slots fill in order, so the first empty slot reached is the next free one.
    assign fill   = active && !slot_valid;

    always_comb begin
        q_next = q_in;
        if (hit || fill) begin
            q_next.done = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg <= '0;
        end else begin
            q_reg <= q_next;
        end
        if (fill) begin
            addr_reg <= q_in.addr;
            sent_reg <= {31'd0, q_in.is_src};
            recv_reg <= {31'd0, !q_in.is_src};
        end else if (hit) begin
            if (q_in.is_src) begin
                sent_reg <= sent_reg + 32'd1;
            end else begin
                recv_reg <= recv_reg + 32'd1;
            end
        end
    end

    assign q_out      = q_reg;
    assign entry_addr = addr_reg;
    assign entry_sent = sent_reg;
    assign entry_recv = recv_reg;

endmodule
`default_nettype wire
